[hw/rtl/bcge_pkg.sv]
package bcge_pkg;

  localparam int OP_W    = 2;
  localparam int BLOCK_W = 32;
  localparam int RUN_W   = 16;
  localparam int KIND_W  = 2;
  localparam int FETCH_W = 5;
  localparam int GEN_W   = 64;

  localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL      = 2'd1;
  localparam logic [OP_W-1:0] OP_READAHEAD = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] block_index_res;
    logic               hit;
    logic [FETCH_W-1:0] fetch_count;
    logic               refused;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               tag_en;
    logic               gen_en;
    logic [BLOCK_W-1:0] tag;
    logic [GEN_W-1:0]   gen;
  } wr_t;

endpackage

[hw/rtl/bcge_req_if.sv]
interface bcge_req_if;
  import bcge_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [BLOCK_W-1:0] block_index;
  logic [RUN_W-1:0]   run_length;

  modport source (output valid, operation, block_index, run_length, input ready);
  modport sink   (input valid, operation, block_index, run_length, output ready);
endinterface

[hw/rtl/bcge_res_if.sv]
interface bcge_res_if;
  import bcge_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BLOCK_W-1:0] block_index_res;
  logic               hit;
  logic [FETCH_W-1:0] fetch_count;
  logic               refused;
  logic               last;

  modport source (output valid, kind, block_index_res, hit, fetch_count, refused, last,
                  input ready);
  modport sink   (input valid, kind, block_index_res, hit, fetch_count, refused, last,
                  output ready);
endinterface

[hw/rtl/bcge_store.sv]
module bcge_store #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
  output logic [bcge_pkg::BLOCK_W-1:0] rd_tag,
  output logic [bcge_pkg::GEN_W-1:0]   rd_gen,
  input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
  input  bcge_pkg::wr_t                wr
);
  import bcge_pkg::*;

  logic [BLOCK_W-1:0] tag_mem [CAPACITY];
  logic [GEN_W-1:0]   gen_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.tag_en) begin
      tag_mem[wr_addr] <= wr.tag;
    end
    if (wr.gen_en) begin
      gen_mem[wr_addr] <= wr.gen;
    end
    rd_tag <= tag_mem[rd_addr];
    rd_gen <= gen_mem[rd_addr];
  end

endmodule

[hw/rtl/bcge_out_reg.sv]
module bcge_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bcge_pkg::res_t din,
  output logic           free,
  bcge_res_if.source     res
);
  import bcge_pkg::*;

  res_t data;
  logic valid;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign res.valid           = valid;
  assign res.kind            = data.kind;
  assign res.block_index_res = data.block_index_res;
  assign res.hit             = data.hit;
  assign res.fetch_count     = data.fetch_count;
  assign res.refused         = data.refused;
  assign res.last            = data.last;

endmodule

[hw/rtl/block_cache_generation_eviction_unit.sv]
// lookup: one directory sweep through the tag/generation memory read port
// clear: straight to the answer; fill and readahead: one sweep, a count of up to MAX_RUN
// blocks, a refusal check for readahead, then one sweep per walked entry in each eviction
// pass (each stalled while an eviction notice waits), then an insertion sweep;
// one item at a time; the result register lets the next request in while an answer waits
// synchronous active-high reset empties the directory and zeroes both generation registers
module block_cache_generation_eviction_unit #(
  parameter int CAPACITY = 64,
  parameter int MAX_RUN  = 16
) (
  input logic        clk,
  input logic        rst,
  bcge_req_if.sink   req,
  bcge_res_if.source res
);
  import bcge_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int PW = $clog2(2 * CAPACITY + 3);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_COUNT  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_PASS   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_INSERT = 4'd6;
  localparam logic [3:0] S_ANSWER = 4'd7;

  localparam logic [1:0] M_LOOK = 2'd0;
  localparam logic [1:0] M_PRES = 2'd1;
  localparam logic [1:0] M_FIND = 2'd2;

  logic [3:0]         state;
  logic [1:0]         mode;
  logic [OP_W-1:0]    op;
  logic [BLOCK_W-1:0] blk;
  logic [RUN_W-1:0]   rem;
  logic               hit;
  logic               refused;
  logic [KIND_W-1:0]  ans_kind;
  logic [MAX_RUN-1:0] mask;
  logic [RW-1:0]      cnt;
  logic [RW-1:0]      inserted;
  logic [CW-1:0]      goal;
  logic [PW-1:0]      passes;
  logic [GEN_W-1:0]   cur_gen;
  logic [GEN_W-1:0]   oldest_gen;
  logic [GEN_W-1:0]   min_gen;
  logic               have_bound;
  logic [BLOCK_W-1:0] bound;
  logic               found;
  logic [BLOCK_W-1:0] best_tag;
  logic [AW-1:0]      best_idx;
  logic [GEN_W-1:0]   best_gen;
  logic [CW-1:0]      sa;
  logic [CW-1:0]      ip;
  logic               pend;
  logic [AW-1:0]      pidx;
  logic [CAPACITY-1:0] valid;
  logic [CW-1:0]      ecount;

  logic [BLOCK_W-1:0] rd_tag;
  logic [GEN_W-1:0]   rd_gen;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  wr_t                wr;
  logic               out_free;
  logic               out_load;
  res_t               out_d;

  logic               accept;
  logic               sweep_done;
  logic               look_match;
  logic               ins_go;
  logic               ins_free;
  logic [BLOCK_W-1:0] diff;
  logic [GEN_W-1:0]   mg_new;
  logic               evict;
  logic [CW-1:0]      cnt_sat;
  logic [CW-1:0]      ecount_dec;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign sweep_done = (sa == CW'(CAPACITY)) && !pend;
  assign rd_addr    = sa[AW-1:0];
  assign diff       = rd_tag - blk;
  assign look_match = (state == S_SCAN) && (mode == M_LOOK) && pend && valid[pidx]
                      && (rd_tag == blk);
  assign ins_go     = (state == S_INSERT) && (ip < CW'(CAPACITY)) && (inserted < cnt);
  assign ins_free   = ins_go && !valid[ip[AW-1:0]];
  assign mg_new     = (best_gen != '0 && best_gen < min_gen) ? best_gen : min_gen;
  assign evict      = (best_gen == oldest_gen) || (best_gen == '0);
  assign ecount_dec = ecount - CW'(1);
  assign cnt_sat    = (32'(cnt) > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(cnt);

  always_comb begin
    wr      = '0;
    wr_addr = ip[AW-1:0];
    if (look_match) begin
      wr.gen_en = 1'b1;
      wr.gen    = cur_gen;
      wr_addr   = pidx;
    end else if (ins_free) begin
      wr.tag_en = 1'b1;
      wr.gen_en = 1'b1;
      wr.tag    = blk + BLOCK_W'(inserted);
      wr.gen    = '0;
    end
  end

  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    if (state == S_DECIDE && found && evict) begin
      out_load              = out_free;
      out_d.kind            = KIND_EVICT;
      out_d.block_index_res = best_tag;
    end else if (state == S_ANSWER) begin
      out_load              = out_free;
      out_d.kind            = ans_kind;
      out_d.block_index_res = blk;
      out_d.hit             = hit;
      out_d.fetch_count     = FETCH_W'(inserted);
      out_d.refused         = refused;
      out_d.last            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      ecount     <= '0;
      cur_gen    <= '0;
      oldest_gen <= '0;
      pend       <= 1'b0;
      sa         <= '0;
    end else begin
      // read pipeline of the directory sweep
      if (state == S_SCAN && sa != CW'(CAPACITY)) begin
        pend <= 1'b1;
        pidx <= sa[AW-1:0];
        sa   <= sa + CW'(1);
      end else begin
        pend <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.operation;
            blk        <= req.block_index;
            rem        <= req.run_length;
            hit        <= 1'b0;
            refused    <= 1'b0;
            inserted   <= '0;
            cnt        <= '0;
            mask       <= '0;
            sa         <= '0;
            have_bound <= 1'b0;
            found      <= 1'b0;
            priority case (req.operation)
              OP_LOOKUP: begin
                mode     <= M_LOOK;
                ans_kind <= KIND_LOOKUP;
                state    <= S_SCAN;
              end
              OP_CLEAR: begin
                valid    <= '0;
                ecount   <= '0;
                ans_kind <= KIND_CLEAR;
                state    <= S_ANSWER;
              end
              default: begin
                mode     <= M_PRES;
                ans_kind <= KIND_FILL;
                state    <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (pend) begin
            unique case (mode)
              M_LOOK: begin
                if (look_match) hit <= 1'b1;
              end
              M_PRES: begin
                for (int j = 0; j < MAX_RUN; j++) begin
                  if (valid[pidx] && diff == BLOCK_W'(j)) mask[j] <= 1'b1;
                end
              end
              default: begin
                if (valid[pidx] && (!have_bound || rd_tag > bound)
                    && (!found || rd_tag < best_tag)) begin
                  found    <= 1'b1;
                  best_tag <= rd_tag;
                  best_idx <= pidx;
                  best_gen <= rd_gen;
                end
              end
            endcase
          end
          if (sweep_done) begin
            unique case (mode)
              M_LOOK:  state <= S_ANSWER;
              M_PRES:  state <= S_COUNT;
              default: state <= S_DECIDE;
            endcase
          end
        end
        S_COUNT: begin
          if (rem != '0 && 32'(cnt) < 32'(MAX_RUN) && !mask[0]) begin
            cnt  <= cnt + RW'(1);
            rem  <= rem - RUN_W'(1);
            mask <= mask >> 1;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt    <= RW'(cnt_sat);
          goal   <= CW'(CAPACITY) - cnt_sat;
          passes <= PW'(2 * CAPACITY + 2);
          if (op == OP_READAHEAD && ecount > CW'(CAPACITY) - cnt_sat) begin
            refused <= 1'b1;
            state   <= S_ANSWER;
          end else begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (ecount > goal && passes != '0) begin
            passes     <= passes - PW'(1);
            min_gen    <= cur_gen;
            have_bound <= 1'b0;
            found      <= 1'b0;
            sa         <= '0;
            mode       <= M_FIND;
            state      <= S_SCAN;
          end else begin
            ip    <= '0;
            state <= S_INSERT;
          end
        end
        S_DECIDE: begin
          if (!found) begin
            oldest_gen <= min_gen;
            state      <= S_PASS;
          end else if (!evict || out_free) begin
            min_gen <= mg_new;
            if (evict) begin
              valid[best_idx] <= 1'b0;
              ecount          <= ecount_dec;
            end
            if (evict && ecount_dec <= goal) begin
              oldest_gen <= mg_new;
              state      <= S_PASS;
            end else begin
              have_bound <= 1'b1;
              bound      <= best_tag;
              found      <= 1'b0;
              sa         <= '0;
              state      <= S_SCAN;
            end
          end
        end
        S_INSERT: begin
          if (ins_go) begin
            if (ins_free) begin
              valid[ip[AW-1:0]] <= 1'b1;
              ecount            <= ecount + CW'(1);
              inserted          <= inserted + RW'(1);
            end
            ip <= ip + CW'(1);
          end else begin
            if (cnt != '0) cur_gen <= cur_gen + GEN_W'(1);
            state <= S_ANSWER;
          end
        end
        S_ANSWER: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bcge_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_gen  (rd_gen),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  bcge_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .din  (out_d),
    .free (out_free),
    .res  (res)
  );

  // fill count and valid bits must agree whenever the block is idle
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(ecount) == $countones(valid)))
    else $error("entry count differs from valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ecount) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  // every eviction transfer is followed by a further result of the same request
  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_d.kind == KIND_EVICT) |-> !out_d.last)
    else $error("eviction notice marked last");

endmodule
